/* rtl/core/dibp_pkg.sv */
package dibp_pkg;

   localparam logic [15:0] MAX_BLOB_BYTES = 16'hFFFF;
   localparam logic [15:0] MIN_BLOB_BYTES = 16'd9;

   localparam logic [7:0] CHAR_SHORT_TAG = 8'h32;  // '2'
   localparam logic [7:0] CHAR_LONG_TAG  = 8'h67;  // 'g'
   localparam logic [7:0] CHAR_DOT       = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_ONE       = 8'h31;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   localparam logic [7:0] MAP_ALL     = 8'h1F;
   localparam logic [7:0] MAP_ID      = 8'h01;
   localparam logic [7:0] MAP_DATE    = 8'h02;
   localparam logic [7:0] MAP_NAME    = 8'h04;
   localparam logic [7:0] MAP_VERSION = 8'h08;
   localparam logic [7:0] MAP_ADD     = 8'h10;

   localparam logic [7:0] VER_ONE   = 8'd1;
   localparam logic [7:0] VER_TWO   = 8'd2;
   localparam logic [7:0] VER_THREE = 8'd3;

   localparam logic [3:0] LEVEL_UNDEFINED = 4'd10;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_TOO_SHORT   = 2'd1;
   localparam logic [1:0] ST_BAD_MAGIC   = 2'd2;
   localparam logic [1:0] ST_BAD_VERSION = 2'd3;

   localparam logic [2:0] FID_ADD = 3'd5;

   typedef enum logic [3:0] {
      PH_MAGIC   = 4'd0,
      PH_VERSION = 4'd1,
      PH_MAP     = 4'd2,
      PH_ID      = 4'd3,
      PH_DATE    = 4'd4,
      PH_TIME    = 4'd5,
      PH_NAME    = 4'd6,
      PH_PVER    = 4'd7,
      PH_ADDLEN  = 4'd8,
      PH_ADD     = 4'd9,
      PH_TRAIL   = 4'd10,
      PH_DONE    = 4'd11,
      PH_ERR     = 4'd12
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       is_status;
      logic [2:0] field_id;
      logic [7:0] field_offset;
      logic [7:0] field_byte;
      logic [1:0] parse_status;
      logic [7:0] block_version;
      logic [7:0] content_flags;
      logic [3:0] info_level;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic    data_valid;
      rsp_type data_item;
      logic    status_valid;
      rsp_type status_item;
   } result_pair_type;

   function automatic logic [7:0] magic_head(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h4C;  // 'L'
         3'd1:    ch = 8'h78;  // 'x'
         3'd2:    ch = 8'h5F;  // '_'
         3'd3:    ch = 8'h3F;  // '?'
         3'd4:    ch = 8'h7A;  // 'z'
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic field_present(input phase_type ph, input logic [7:0] map);
      logic pr;
      unique case (ph)
         PH_ID:           pr = (map & MAP_ID) != 8'd0;
         PH_DATE, PH_TIME: pr = (map & MAP_DATE) != 8'd0;
         PH_NAME:         pr = (map & MAP_NAME) != 8'd0;
         PH_PVER:         pr = (map & (MAP_NAME | MAP_VERSION)) == (MAP_NAME | MAP_VERSION);
         PH_ADDLEN:       pr = (map & MAP_ADD) != 8'd0;
         default:         pr = 1'b0;
      endcase
      return pr;
   endfunction

   function automatic logic [7:0] field_len(input phase_type ph, input logic [7:0] ver);
      logic [1:0] vi;
      logic [7:0] len;
      vi = 2'(ver - 8'd1);
      if (vi == 2'd3) begin
         vi = 2'd2;
      end
      unique case (ph)
         PH_ID:   len = (vi == 2'd0) ? 8'd16 : (vi == 2'd1) ? 8'd17 : 8'd29;
         PH_DATE: len = (vi == 2'd0) ? 8'd11 : 8'd12;
         PH_TIME: len = (vi == 2'd0) ? 8'd8 : 8'd9;
         PH_NAME: len = (vi == 2'd0) ? 8'd15 : (vi == 2'd1) ? 8'd16 : 8'd33;
         PH_PVER: len = (vi == 2'd0) ? 8'd10 : (vi == 2'd1) ? 8'd11 : 8'd17;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

   // first present field at or after 'from'; else trail if any came before, or done
   function automatic phase_type next_field(input phase_type from, input logic [7:0] map,
                                            input logic any_before);
      phase_type res;
      logic      found;
      res   = any_before ? PH_TRAIL : PH_DONE;
      found = 1'b0;
      for (int p = int'(PH_ID); p <= int'(PH_ADDLEN); p++) begin
         if (!found && (4'(p) >= 4'(from)) && field_present(phase_type'(4'(p)), map)) begin
            res   = phase_type'(4'(p));
            found = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

/* rtl/core/device_info_block_parser.sv */
// channel  | ports                        | direction | payload
// ---------+------------------------------+-----------+-----------------------
// request  | req_valid req_stall req_data | in        | dibp_pkg::req_type
// response | rsp_valid rsp_stall rsp_data | out       | dibp_pkg::rsp_type
//
// One item is taken per cycle while req_stall is low; its results are pushed
// into a four-entry result queue in the same edge and can leave from the next cycle.
// An item with a field byte and the final status gives two results, so the
// response side, one result per cycle while rsp_stall is low, sets the sustained rate then.
// req_stall rises when fewer than two queue entries are free.
// Synchronous reset clears the parse state and empties the queue.
module device_info_block_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dibp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dibp_pkg::rsp_type rsp_data
);

   dibp_pkg::result_pair_type results;
   dibp_pkg::rsp_type         queue_ff [4];
   logic [1:0]                wr_ptr_ff, wr_ptr_in;
   logic [1:0]                rd_ptr_ff, rd_ptr_in;
   logic [2:0]                count_ff, count_in;
   logic                      req_accept;
   logic                      rsp_accept;
   logic [1:0]                push_count;
   dibp_pkg::rsp_type         first_item;

   assign req_stall  = count_ff > 3'd2;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = count_ff != 3'd0;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_data   = queue_ff[rd_ptr_ff];

   dibp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .item    (req_data),
      .results (results)
   );

   always_comb begin
      push_count = 2'({1'b0, results.data_valid}) + 2'({1'b0, results.status_valid});
      first_item = results.data_valid ? results.data_item : results.status_item;
      wr_ptr_in  = wr_ptr_ff + push_count;
      rd_ptr_in  = rd_ptr_ff + 2'({1'b0, rsp_accept});
      count_in   = count_ff + 3'(push_count) - 3'({2'b00, rsp_accept});
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_item;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= results.status_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/dibp_parser.sv */
module dibp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  dibp_pkg::req_type        item,
   output dibp_pkg::result_pair_type results
);

   logic [15:0]         pos_ff, pos_in;
   dibp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          fcl_ff, fcl_in;
   logic                long_ff, long_in;
   logic [7:0]          ver_ff, ver_in;
   logic [7:0]          map_ff, map_in;
   logic [3:0]          lvl_ff, lvl_in;
   logic [1:0]          err_ff, err_in;
   logic [7:0]          add_total_ff, add_total_in;

   logic [7:0]          d;
   logic [1:0]          st;

   always_comb begin
      d            = item.data_byte;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      fcl_in       = fcl_ff;
      long_in      = long_ff;
      ver_in       = ver_ff;
      map_in       = map_ff;
      lvl_in       = lvl_ff;
      err_in       = err_ff;
      add_total_in = add_total_ff;
      st           = dibp_pkg::ST_OK;
      results      = '0;

      if (pos_ff != dibp_pkg::MAX_BLOB_BYTES) begin
         pos_in = pos_ff + 16'd1;
         unique case (phase_ff)
            dibp_pkg::PH_MAGIC: begin
               if (pos_ff < 16'd5) begin
                  if (d != dibp_pkg::magic_head(pos_ff[2:0])) begin
                     err_in   = dibp_pkg::ST_BAD_MAGIC;
                     phase_in = dibp_pkg::PH_ERR;
                  end
               end else if (pos_ff == 16'd5) begin
                  if (d == dibp_pkg::CHAR_SHORT_TAG) begin
                     long_in = 1'b0;
                  end else if (d == dibp_pkg::CHAR_LONG_TAG) begin
                     long_in = 1'b1;
                  end else begin
                     err_in   = dibp_pkg::ST_BAD_MAGIC;
                     phase_in = dibp_pkg::PH_ERR;
                  end
               end else if (pos_ff == 16'd6) begin
                  if (d == dibp_pkg::CHAR_DOT) begin
                     lvl_in = 4'd0;
                  end else if (d >= dibp_pkg::CHAR_ONE && d <= dibp_pkg::CHAR_NINE) begin
                     lvl_in = 4'(d - dibp_pkg::CHAR_ZERO);
                  end else begin
                     lvl_in = dibp_pkg::LEVEL_UNDEFINED;
                  end
                  if (!long_ff) begin
                     phase_in = dibp_pkg::PH_VERSION;
                  end
               end else begin
                  if (d != 8'd0) begin
                     err_in   = dibp_pkg::ST_BAD_MAGIC;
                     phase_in = dibp_pkg::PH_ERR;
                  end else begin
                     phase_in = dibp_pkg::PH_VERSION;
                  end
               end
            end
            dibp_pkg::PH_VERSION: begin
               ver_in = d;
               if (d == dibp_pkg::VER_THREE) begin
                  map_in   = dibp_pkg::MAP_ALL;
                  phase_in = dibp_pkg::next_field(dibp_pkg::PH_ID, dibp_pkg::MAP_ALL, 1'b0);
                  fcl_in   = dibp_pkg::field_len(phase_in, d);
               end else if (d == dibp_pkg::VER_ONE || d == dibp_pkg::VER_TWO) begin
                  phase_in = dibp_pkg::PH_MAP;
               end else begin
                  err_in   = dibp_pkg::ST_BAD_VERSION;
                  phase_in = dibp_pkg::PH_ERR;
               end
            end
            dibp_pkg::PH_MAP: begin
               map_in   = d;
               phase_in = dibp_pkg::next_field(dibp_pkg::PH_ID, d, 1'b0);
               fcl_in   = dibp_pkg::field_len(phase_in, ver_ff);
            end
            dibp_pkg::PH_ID, dibp_pkg::PH_DATE, dibp_pkg::PH_TIME, dibp_pkg::PH_NAME,
            dibp_pkg::PH_PVER: begin
               results.data_valid             = 1'b1;
               results.data_item.field_id     = 3'(phase_ff - dibp_pkg::PH_ID);
               results.data_item.field_offset = dibp_pkg::field_len(phase_ff, ver_ff) - fcl_ff;
               results.data_item.field_byte   = d;
               fcl_in = fcl_ff - 8'd1;
               if (fcl_ff == 8'd1) begin
                  phase_in = dibp_pkg::next_field(dibp_pkg::phase_type'(phase_ff + 4'd1),
                                                  map_ff, 1'b1);
                  fcl_in   = dibp_pkg::field_len(phase_in, ver_ff);
               end
            end
            dibp_pkg::PH_ADDLEN: begin
               if (d == 8'd0) begin
                  phase_in = dibp_pkg::PH_TRAIL;
               end else begin
                  add_total_in = d;
                  fcl_in       = d;
                  phase_in     = dibp_pkg::PH_ADD;
               end
            end
            dibp_pkg::PH_ADD: begin
               results.data_valid             = 1'b1;
               results.data_item.field_id     = dibp_pkg::FID_ADD;
               results.data_item.field_offset = add_total_ff - fcl_ff;
               results.data_item.field_byte   = d;
               fcl_in = fcl_ff - 8'd1;
               if (fcl_ff == 8'd1) begin
                  phase_in = dibp_pkg::PH_DONE;
               end
            end
            dibp_pkg::PH_TRAIL: begin
               phase_in = dibp_pkg::PH_DONE;
            end
            dibp_pkg::PH_DONE, dibp_pkg::PH_ERR: begin
            end
            default: begin
            end
         endcase
      end

      results.data_item.run_end = !item.last_byte;

      if (item.last_byte) begin
         if (pos_in < dibp_pkg::MIN_BLOB_BYTES) begin
            st = dibp_pkg::ST_TOO_SHORT;
         end else if (phase_in == dibp_pkg::PH_ERR) begin
            st = err_in;
         end else if (phase_in == dibp_pkg::PH_DONE) begin
            st = dibp_pkg::ST_OK;
         end else begin
            st = dibp_pkg::ST_TOO_SHORT;
         end
         results.status_valid               = 1'b1;
         results.status_item.is_status      = 1'b1;
         results.status_item.parse_status   = st;
         results.status_item.block_version  = ver_in;
         results.status_item.content_flags  = map_in;
         results.status_item.info_level     = lvl_in;
         results.status_item.run_end        = 1'b1;
         // next block starts from scratch
         pos_in       = 16'd0;
         phase_in     = dibp_pkg::PH_MAGIC;
         fcl_in       = 8'd0;
         long_in      = 1'b0;
         ver_in       = 8'd0;
         map_in       = 8'd0;
         lvl_in       = dibp_pkg::LEVEL_UNDEFINED;
         err_in       = dibp_pkg::ST_OK;
         add_total_in = 8'd0;
      end

      if (!accept) begin
         results.data_valid   = 1'b0;
         results.status_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 16'd0;
         phase_ff     <= dibp_pkg::PH_MAGIC;
         fcl_ff       <= 8'd0;
         long_ff      <= 1'b0;
         ver_ff       <= 8'd0;
         map_ff       <= 8'd0;
         lvl_ff       <= dibp_pkg::LEVEL_UNDEFINED;
         err_ff       <= dibp_pkg::ST_OK;
         add_total_ff <= 8'd0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         fcl_ff       <= fcl_in;
         long_ff      <= long_in;
         ver_ff       <= ver_in;
         map_ff       <= map_in;
         lvl_ff       <= lvl_in;
         err_ff       <= err_in;
         add_total_ff <= add_total_in;
      end
   end

endmodule

/* verif/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // field lengths for versions 1, 2 and 3, lowest byte first
   localparam logic [23:0] LEN_ID   = {8'd29, 8'd17, 8'd16};
   localparam logic [23:0] LEN_DATE = {8'd12, 8'd12, 8'd11};
   localparam logic [23:0] LEN_TIME = {8'd9, 8'd9, 8'd8};
   localparam logic [23:0] LEN_NAME = {8'd33, 8'd16, 8'd15};
   localparam logic [23:0] LEN_PVER = {8'd17, 8'd11, 8'd10};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dibp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   dibp_pkg::rsp_type rsp_data;

   logic    steady = 1'b0;
   int      error_count = 0;
   int      items_sent = 0;

   dibp_pkg::rsp_type expected_results[$];
   logic [7:0]        blob_bytes[$];

   // parser state as predicted
   logic [15:0] blob_pos;
   logic [3:0]  cur_phase;
   logic [7:0]  left_count;
   logic        long_tag;
   logic [7:0]  seen_version;
   logic [7:0]  seen_map;
   logic [3:0]  seen_level;
   logic [1:0]  err_status;
   logic [7:0]  add_length;

   device_info_block_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 32);
   end

   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = "L";
         3'd1:    ch = "x";
         3'd2:    ch = "_";
         3'd3:    ch = "?";
         default: ch = "z";
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] fixed_length(input logic [3:0] ph, input logic [7:0] ver);
      logic [1:0]  vi;
      logic [23:0] row;
      vi = 2'(ver - 8'd1);
      if (vi == 2'd3) begin
         vi = 2'd2;
      end
      case (ph)
         dibp_pkg::PH_ID:   row = LEN_ID;
         dibp_pkg::PH_DATE: row = LEN_DATE;
         dibp_pkg::PH_TIME: row = LEN_TIME;
         dibp_pkg::PH_NAME: row = LEN_NAME;
         dibp_pkg::PH_PVER: row = LEN_PVER;
         default:           row = '0;
      endcase
      return row[vi*8 +: 8];
   endfunction

   function automatic logic field_here(input logic [3:0] ph, input logic [7:0] map);
      logic here;
      case (ph)
         dibp_pkg::PH_ID:                     here = map[0];
         dibp_pkg::PH_DATE, dibp_pkg::PH_TIME: here = map[1];
         dibp_pkg::PH_NAME:                   here = map[2];
         dibp_pkg::PH_PVER:                   here = map[2] & map[3];
         dibp_pkg::PH_ADDLEN:                 here = map[4];
         default:                             here = 1'b0;
      endcase
      return here;
   endfunction

   task automatic clear_model();
      blob_pos     = '0;
      cur_phase    = dibp_pkg::PH_MAGIC;
      left_count   = '0;
      long_tag     = 1'b0;
      seen_version = '0;
      seen_map     = '0;
      seen_level   = dibp_pkg::LEVEL_UNDEFINED;
      err_status   = dibp_pkg::ST_OK;
      add_length   = '0;
   endtask

   task automatic enter_error(input logic [1:0] code);
      err_status = code;
      cur_phase  = dibp_pkg::PH_ERR;
   endtask

   task automatic enter_field(input logic [3:0] from, input logic any_before);
      logic found;
      found = 1'b0;
      for (int p = dibp_pkg::PH_ID; p <= dibp_pkg::PH_ADDLEN; p++) begin
         if (!found && p >= from && field_here(4'(p), seen_map)) begin
            found      = 1'b1;
            cur_phase  = 4'(p);
            left_count = (p == dibp_pkg::PH_ADDLEN) ? 8'd0 :
                         fixed_length(4'(p), seen_version);
         end
      end
      if (!found) begin
         cur_phase = any_before ? dibp_pkg::PH_TRAIL : dibp_pkg::PH_DONE;
      end
   endtask

   task automatic model_byte(input logic [7:0] d, input logic last);
      dibp_pkg::rsp_type data_res;
      dibp_pkg::rsp_type stat_res;
      logic              have_data;
      logic [7:0]        len;
      have_data = 1'b0;
      data_res  = '0;
      stat_res  = '0;
      if (blob_pos < dibp_pkg::MAX_BLOB_BYTES) begin
         case (cur_phase)
            dibp_pkg::PH_MAGIC: begin
               if (blob_pos < 16'd5) begin
                  if (d != magic_char(blob_pos[2:0])) begin
                     enter_error(dibp_pkg::ST_BAD_MAGIC);
                  end
               end else if (blob_pos == 16'd5) begin
                  if (d == dibp_pkg::CHAR_SHORT_TAG) begin
                     long_tag = 1'b0;
                  end else if (d == dibp_pkg::CHAR_LONG_TAG) begin
                     long_tag = 1'b1;
                  end else begin
                     enter_error(dibp_pkg::ST_BAD_MAGIC);
                  end
               end else if (blob_pos == 16'd6) begin
                  if (d == dibp_pkg::CHAR_DOT) begin
                     seen_level = 4'd0;
                  end else if (d >= dibp_pkg::CHAR_ONE && d <= dibp_pkg::CHAR_NINE) begin
                     seen_level = 4'(d - dibp_pkg::CHAR_ZERO);
                  end else begin
                     seen_level = dibp_pkg::LEVEL_UNDEFINED;
                  end
                  if (!long_tag) begin
                     cur_phase = dibp_pkg::PH_VERSION;
                  end
               end else if (d != 8'd0) begin
                  enter_error(dibp_pkg::ST_BAD_MAGIC);
               end else begin
                  cur_phase = dibp_pkg::PH_VERSION;
               end
            end
            dibp_pkg::PH_VERSION: begin
               seen_version = d;
               if (d == dibp_pkg::VER_THREE) begin
                  seen_map = dibp_pkg::MAP_ALL;
                  enter_field(dibp_pkg::PH_ID, 1'b0);
               end else if (d == dibp_pkg::VER_ONE || d == dibp_pkg::VER_TWO) begin
                  cur_phase = dibp_pkg::PH_MAP;
               end else begin
                  enter_error(dibp_pkg::ST_BAD_VERSION);
               end
            end
            dibp_pkg::PH_MAP: begin
               seen_map = d;
               enter_field(dibp_pkg::PH_ID, 1'b0);
            end
            dibp_pkg::PH_ID, dibp_pkg::PH_DATE, dibp_pkg::PH_TIME, dibp_pkg::PH_NAME,
            dibp_pkg::PH_PVER: begin
               len                   = fixed_length(cur_phase, seen_version);
               have_data             = 1'b1;
               data_res.field_id     = 3'(cur_phase - dibp_pkg::PH_ID);
               data_res.field_offset = len - left_count;
               data_res.field_byte   = d;
               left_count--;
               if (left_count == 8'd0) begin
                  enter_field(cur_phase + 4'd1, 1'b1);
               end
            end
            dibp_pkg::PH_ADDLEN: begin
               if (d == 8'd0) begin
                  cur_phase = dibp_pkg::PH_TRAIL;
               end else begin
                  left_count = d;
                  add_length = d;
                  cur_phase  = dibp_pkg::PH_ADD;
               end
            end
            dibp_pkg::PH_ADD: begin
               have_data             = 1'b1;
               data_res.field_id     = dibp_pkg::FID_ADD;
               data_res.field_offset = add_length - left_count;
               data_res.field_byte   = d;
               left_count--;
               if (left_count == 8'd0) begin
                  cur_phase = dibp_pkg::PH_DONE;
               end
            end
            dibp_pkg::PH_TRAIL: cur_phase = dibp_pkg::PH_DONE;
            default: ;
         endcase
         blob_pos++;
      end
      if (have_data) begin
         data_res.run_end = !last;
         expected_results.push_back(data_res);
      end
      if (last) begin
         stat_res.is_status = 1'b1;
         if (blob_pos < dibp_pkg::MIN_BLOB_BYTES) begin
            stat_res.parse_status = dibp_pkg::ST_TOO_SHORT;
         end else if (cur_phase == dibp_pkg::PH_ERR) begin
            stat_res.parse_status = err_status;
         end else if (cur_phase == dibp_pkg::PH_DONE) begin
            stat_res.parse_status = dibp_pkg::ST_OK;
         end else begin
            stat_res.parse_status = dibp_pkg::ST_TOO_SHORT;
         end
         stat_res.block_version = seen_version;
         stat_res.content_flags = seen_map;
         stat_res.info_level    = seen_level;
         stat_res.run_end       = 1'b1;
         expected_results.push_back(stat_res);
         clear_model();
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      dibp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result with no item waiting: %p", rsp_data);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("is_status", want.is_status, rsp_data.is_status);
            compare_field("field_id", want.field_id, rsp_data.field_id);
            compare_field("field_offset", want.field_offset, rsp_data.field_offset);
            compare_field("field_byte", want.field_byte, rsp_data.field_byte);
            compare_field("parse_status", want.parse_status, rsp_data.parse_status);
            compare_field("block_version", want.block_version, rsp_data.block_version);
            compare_field("content_flags", want.content_flags, rsp_data.content_flags);
            compare_field("info_level", want.info_level, rsp_data.info_level);
            compare_field("run_end", want.run_end, rsp_data.run_end);
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic last);
      dibp_pkg::req_type item;
      item.data_byte = d;
      item.last_byte = last;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      model_byte(d, last);
      items_sent++;
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_blob();
      for (int i = 0; i < blob_bytes.size(); i++) begin
         send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic build_block(input logic [7:0] ver, input logic [7:0] map,
                              input logic long_form, input logic [7:0] level,
                              input int add_len, input int trail);
      logic [7:0] eff_map;
      blob_bytes.delete();
      for (int i = 0; i < 5; i++) begin
         blob_bytes.push_back(magic_char(3'(i)));
      end
      blob_bytes.push_back(long_form ? dibp_pkg::CHAR_LONG_TAG : dibp_pkg::CHAR_SHORT_TAG);
      blob_bytes.push_back(level);
      if (long_form) begin
         blob_bytes.push_back(8'h00);
      end
      blob_bytes.push_back(ver);
      if (ver == dibp_pkg::VER_ONE || ver == dibp_pkg::VER_TWO) begin
         blob_bytes.push_back(map);
      end
      eff_map = (ver == dibp_pkg::VER_THREE) ? dibp_pkg::MAP_ALL : map;
      if (ver >= dibp_pkg::VER_ONE && ver <= dibp_pkg::VER_THREE) begin
         for (int p = dibp_pkg::PH_ID; p <= dibp_pkg::PH_PVER; p++) begin
            if (field_here(4'(p), eff_map)) begin
               repeat (fixed_length(4'(p), ver)) blob_bytes.push_back(8'($urandom));
            end
         end
         if ((eff_map & dibp_pkg::MAP_ADD) != 8'd0) begin
            blob_bytes.push_back(8'(add_len));
            repeat (add_len) blob_bytes.push_back(8'($urandom));
         end
      end
      repeat (trail) blob_bytes.push_back(8'($urandom));
   endtask

   task automatic test_short_blobs();
      logic [7:0] junk;
      blob_bytes.delete();
      blob_bytes.push_back(8'hFF);
      send_blob();
      build_block(dibp_pkg::VER_ONE, 8'h00, 1'b0, dibp_pkg::CHAR_DOT, 0, 0);
      junk = blob_bytes.pop_back();
      send_blob();
   endtask

   task automatic test_bad_magic();
      build_block(dibp_pkg::VER_ONE, 8'h00, 1'b0, dibp_pkg::CHAR_DOT, 0, 0);
      blob_bytes[5] = "Q";
      send_blob();
      build_block(dibp_pkg::VER_ONE, 8'h00, 1'b1, "3", 0, 0);
      blob_bytes[7] = 8'h80;
      send_blob();
   endtask

   task automatic test_bad_version();
      build_block(8'd0, 8'h00, 1'b0, dibp_pkg::CHAR_NINE, 0, 1);
      send_blob();
      build_block(8'hFF, 8'h00, 1'b1, dibp_pkg::CHAR_ZERO, 0, 1);
      send_blob();
   endtask

   task automatic test_missing_map();
      logic [7:0] junk;
      build_block(dibp_pkg::VER_ONE, 8'h00, 1'b1, dibp_pkg::CHAR_DOT, 0, 0);
      junk = blob_bytes.pop_back();
      send_blob();
   endtask

   task automatic test_empty_map();
      build_block(dibp_pkg::VER_TWO, 8'h00, 1'b0, "5", 0, 0);
      send_blob();
      // version bit alone selects nothing
      build_block(dibp_pkg::VER_ONE, dibp_pkg::MAP_VERSION, 1'b1, ":", 0, 2);
      send_blob();
   endtask

   task automatic test_field_lengths();
      build_block(dibp_pkg::VER_ONE, dibp_pkg::MAP_ALL, 1'b0, dibp_pkg::CHAR_DOT, 0, 1);
      send_blob();
      build_block(dibp_pkg::VER_TWO, 8'hFF, 1'b1, dibp_pkg::CHAR_ONE, 1, 0);
      send_blob();
      build_block(dibp_pkg::VER_THREE, 8'h00, 1'b0, dibp_pkg::CHAR_NINE, 255, 2);
      send_blob();
   endtask

   task automatic test_random_blocks(input int target);
      int         start;
      int         pick;
      int         keep;
      int         idx;
      logic [7:0] ver;
      logic [7:0] map;
      logic [7:0] level;
      logic [7:0] junk;
      int         add_len;
      start = items_sent;
      while (items_sent - start < target) begin
         pick = $urandom_range(9);
         if (pick < 3) begin
            ver = dibp_pkg::VER_ONE;
         end else if (pick < 6) begin
            ver = dibp_pkg::VER_TWO;
         end else if (pick < 9) begin
            ver = dibp_pkg::VER_THREE;
         end else begin
            ver = 8'($urandom);
         end
         map = ($urandom_range(3) == 0) ? dibp_pkg::MAP_ALL : 8'($urandom);
         case ($urandom_range(3))
            0:       level = dibp_pkg::CHAR_DOT;
            1, 2:    level = 8'(dibp_pkg::CHAR_ZERO + $urandom_range(9));
            default: level = 8'($urandom);
         endcase
         pick = $urandom_range(19);
         if (pick == 0) begin
            add_len = 255;
         end else if (pick == 1) begin
            add_len = $urandom_range(255);
         end else begin
            add_len = $urandom_range(6);
         end
         build_block(ver, map, 1'($urandom), level, add_len, $urandom_range(3));
         pick = $urandom_range(99);
         if (pick < 12) begin
            keep = $urandom_range(blob_bytes.size(), 1);
            while (blob_bytes.size() > keep) begin
               junk = blob_bytes.pop_back();
            end
         end else if (pick < 22) begin
            idx = $urandom_range(7);
            blob_bytes[idx] = 8'($urandom);
         end else if (pick < 27) begin
            blob_bytes.delete();
            repeat ($urandom_range(24, 1)) blob_bytes.push_back(8'($urandom));
         end
         send_blob();
      end
   endtask

   task automatic test_no_idling();
      steady <= 1'b1;
      test_random_blocks(400);
      drain_results();
      steady <= 1'b0;
   endtask

   initial begin
      clear_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_short_blobs();
      drain_results();
      test_bad_magic();
      drain_results();
      test_bad_version();
      test_missing_map();
      test_empty_map();
      drain_results();
      test_field_lengths();
      drain_results();
      test_no_idling();
      test_random_blocks(960);
      drain_results();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
